### rtl/core/range_fault_debounce_monitor_unit_assert.svh
// Assertion macros used by the range fault debounce monitor RTL
`ifndef RANGE_FAULT_DEBOUNCE_MONITOR_UNIT_ASSERT_SVH
`define RANGE_FAULT_DEBOUNCE_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RFDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rfdm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RFDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfdm: next-cycle check failed");

`endif

### rtl/core/rfdm_pkg.sv
// Types and constants of the range fault debounce monitor
`timescale 1ns / 1ps

package rfdm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 16;
	localparam int CNT_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [1:0] {
		MODE_ABOVE  = 2'd0,
		MODE_BELOW  = 2'd1,
		MODE_WINDOW = 2'd2,
		MODE_OFF    = 2'd3
	} range_mode_t;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_PENDING   = 2'd1,
		ST_CONFIRMED = 2'd2
	} fault_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_MODE     = 3'd0,
		REG_HIGH_THRESHOLD = 3'd1,
		REG_HIGH_RELEASE   = 3'd2,
		REG_LOW_THRESHOLD  = 3'd3,
		REG_LOW_RELEASE    = 3'd4,
		REG_CONFIRM_COUNT  = 3'd5,
		REG_CLEAR_COUNT    = 3'd6
	} cfg_reg_t;

	localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 16'd32000;
	localparam logic [LEVEL_W-1:0] HIGH_RELEASE_RST   = 16'd31000;
	localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST  = 16'd2000;
	localparam logic [LEVEL_W-1:0] LOW_RELEASE_RST    = 16'd2100;
	localparam logic [CNT_W-1:0]   CONFIRM_COUNT_RST  = 8'd3;
	localparam logic [CNT_W-1:0]   CLEAR_COUNT_RST    = 8'd5;

	typedef struct packed {
		range_mode_t        mode;
		logic [LEVEL_W-1:0] high_threshold;
		logic [LEVEL_W-1:0] high_release;
		logic [LEVEL_W-1:0] low_threshold;
		logic [LEVEL_W-1:0] low_release;
		logic [CNT_W-1:0]   confirm_count;
		logic [CNT_W-1:0]   clear_count;
	} cfg_t;

	typedef struct packed {
		fault_state_t fault_state;
		logic         raw_fault;
	} result_t;

endpackage

### rtl/core/rfdm_eval.sv
// Hysteresis flag and debounce state machine for one sample per cycle while step is high
`timescale 1ns / 1ps
`include "range_fault_debounce_monitor_unit_assert.svh"

module rfdm_eval #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rfdm_pkg::cfg_t                cfg,
	input  logic                          step,
	input  logic [rfdm_pkg::SAMPLE_W-1:0] sample,
	output rfdm_pkg::result_t             res
);

	localparam int UsedW = (SAMPLE_BITS < rfdm_pkg::SAMPLE_W) ? SAMPLE_BITS : rfdm_pkg::SAMPLE_W;
	localparam logic [rfdm_pkg::SAMPLE_W-1:0] SampleMask =
		rfdm_pkg::SAMPLE_W'((33'd1 << UsedW) - 33'd1);
	localparam int CmpW = (COUNT_BITS > rfdm_pkg::CNT_W) ? COUNT_BITS : rfdm_pkg::CNT_W;
	localparam logic [COUNT_BITS-1:0] TallyMax = '1;

	rfdm_pkg::fault_state_t state_q, state_d;
	logic                   flag_q, flag_d;
	logic [COUNT_BITS-1:0]  detect_q, detect_d;
	logic [COUNT_BITS-1:0]  clean_q, clean_d;

	logic [rfdm_pkg::SAMPLE_W-1:0] s;
	logic                          over_hi, under_lo, below_hrel, above_lrel;
	logic [COUNT_BITS-1:0]         detect_inc, clean_inc;
	logic                          confirm_hit, clear_hit;
	logic                          detecting;

	assign s          = sample & SampleMask;
	assign over_hi    = s > cfg.high_threshold;
	assign under_lo   = s < cfg.low_threshold;
	assign below_hrel = s < cfg.high_release;
	assign above_lrel = s > cfg.low_release;

	// raise wins over release
	always_comb begin
		case (cfg.mode)
			rfdm_pkg::MODE_ABOVE:  flag_d = over_hi | (~below_hrel & flag_q);
			rfdm_pkg::MODE_BELOW:  flag_d = under_lo | (~above_lrel & flag_q);
			rfdm_pkg::MODE_WINDOW: flag_d = over_hi | under_lo |
				(~(above_lrel & below_hrel) & flag_q);
			default:               flag_d = 1'b0;
		endcase
	end

	// saturating tallies
	assign detect_inc  = (detect_q == TallyMax) ? detect_q : detect_q + 1'b1;
	assign clean_inc   = (clean_q == TallyMax) ? clean_q : clean_q + 1'b1;
	assign confirm_hit = CmpW'(detect_inc) >= CmpW'(cfg.confirm_count);
	assign clear_hit   = CmpW'(clean_inc) >= CmpW'(cfg.clear_count);
	assign detecting   = flag_d && (state_q == rfdm_pkg::ST_NONE || state_q == rfdm_pkg::ST_PENDING);

	// next state
	always_comb begin
		case (state_q)
			rfdm_pkg::ST_PENDING: begin
				if (flag_d) begin
					state_d = confirm_hit ? rfdm_pkg::ST_CONFIRMED : rfdm_pkg::ST_PENDING;
				end else begin
					state_d = rfdm_pkg::ST_NONE;
				end
			end
			rfdm_pkg::ST_CONFIRMED: begin
				if (!flag_d && clear_hit) begin
					state_d = rfdm_pkg::ST_NONE;
				end else begin
					state_d = rfdm_pkg::ST_CONFIRMED;
				end
			end
			default: begin
				if (flag_d) begin
					state_d = confirm_hit ? rfdm_pkg::ST_CONFIRMED : rfdm_pkg::ST_PENDING;
				end else begin
					state_d = rfdm_pkg::ST_NONE;
				end
			end
		endcase
	end

	// tally updates
	always_comb begin
		detect_d = '0;
		clean_d  = '0;
		if (detecting) begin
			detect_d = detect_inc;
		end else if (!flag_d && state_q == rfdm_pkg::ST_CONFIRMED) begin
			clean_d = clean_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rfdm_pkg::ST_NONE;
			flag_q   <= 1'b0;
			detect_q <= '0;
			clean_q  <= '0;
		end else if (step) begin
			state_q  <= state_d;
			flag_q   <= flag_d;
			detect_q <= detect_d;
			clean_q  <= clean_d;
		end
	end

	assign res.fault_state = state_d;
	assign res.raw_fault   = flag_d;

	`RFDM_ASSERT_NOW(a_tally_exclusive, clk, arst_n, 1'b1, (detect_q == '0 || clean_q == '0))
	`RFDM_ASSERT_NEXT(a_off_clears_flag, clk, arst_n,
		(step && cfg.mode == rfdm_pkg::MODE_OFF), (!flag_q))
	`RFDM_ASSERT_NEXT(a_clean_not_confirmed, clk, arst_n,
		(step && !flag_d && state_q != rfdm_pkg::ST_CONFIRMED),
		(state_q == rfdm_pkg::ST_NONE))

endmodule

### rtl/core/range_fault_debounce_monitor_unit.sv
// Range fault debounce monitor: one sample compared, debounced and reported per transaction.
// Accepts one sample per clock while s_axis_tready is high and returns one result per sample,
// in order, through the input register and then the result register. The flag and the debounce
// state machine update once per sample in the stage between those registers, so back-to-back
// samples are handled at full rate; the two registers give two entries of buffering, and
// s_axis_tready follows m_axis_tready when both are full. No clearing pass after reset.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, by the user only while no
// sample is in flight (not enforced by the block); an index beyond the register list is ignored.
`timescale 1ns / 1ps

module range_fault_debounce_monitor_unit #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rfdm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rfdm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [rfdm_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [15:0] sample
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [rfdm_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [1:0] fault_state, [2] raw_fault
);

	rfdm_pkg::cfg_t                cfg_q;
	logic                          valid_s1;
	logic [rfdm_pkg::SAMPLE_W-1:0] sample_s1;
	logic                          out_valid_q;
	rfdm_pkg::result_t             out_q;
	rfdm_pkg::result_t             res;
	logic                          advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= rfdm_pkg::MODE_ABOVE;
			cfg_q.high_threshold <= rfdm_pkg::HIGH_THRESHOLD_RST;
			cfg_q.high_release   <= rfdm_pkg::HIGH_RELEASE_RST;
			cfg_q.low_threshold  <= rfdm_pkg::LOW_THRESHOLD_RST;
			cfg_q.low_release    <= rfdm_pkg::LOW_RELEASE_RST;
			cfg_q.confirm_count  <= rfdm_pkg::CONFIRM_COUNT_RST;
			cfg_q.clear_count    <= rfdm_pkg::CLEAR_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rfdm_pkg::REG_RANGE_MODE:     cfg_q.mode <= rfdm_pkg::range_mode_t'(cfg_wdata[1:0]);
				rfdm_pkg::REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_wdata;
				rfdm_pkg::REG_HIGH_RELEASE:   cfg_q.high_release <= cfg_wdata;
				rfdm_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold <= cfg_wdata;
				rfdm_pkg::REG_LOW_RELEASE:    cfg_q.low_release <= cfg_wdata;
				rfdm_pkg::REG_CONFIRM_COUNT:  cfg_q.confirm_count <= cfg_wdata[rfdm_pkg::CNT_W-1:0];
				rfdm_pkg::REG_CLEAR_COUNT:    cfg_q.clear_count <= cfg_wdata[rfdm_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata;
		end
	end

	rfdm_eval #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (advance),
		.sample (sample_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_q.raw_fault, out_q.fault_state};

endmodule

### dv/tb_range_fault_debounce_monitor_unit.sv
// Self-checking testbench for the range fault debounce monitor: directed and random samples.
`timescale 1ns / 1ps

module tb_range_fault_debounce_monitor_unit;

	localparam int SETTLE_CYCLES  = 4;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int RANDOM_SAMPLES = 650;
	localparam logic [rfdm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {PICK_HIGH, PICK_LOW, PICK_CLEAN, PICK_EDGE, PICK_ANY} pick_t;

	// Mirrors the flag hysteresis and the debounce state machine; holds the expected statuses.
	class fault_status_tracker;
		rfdm_pkg::cfg_t                cfg;
		logic                          raw_flag;
		logic [rfdm_pkg::CNT_W-1:0]    detect_run;
		logic [rfdm_pkg::CNT_W-1:0]    clean_run;
		rfdm_pkg::fault_state_t        status;
		rfdm_pkg::result_t             status_due[$];
		int                            mismatches;
		int                            checked;
		int                            confirmed_seen;
		int                            raw_seen;

		function new();
			cfg.mode           = rfdm_pkg::MODE_ABOVE;
			cfg.high_threshold = rfdm_pkg::HIGH_THRESHOLD_RST;
			cfg.high_release   = rfdm_pkg::HIGH_RELEASE_RST;
			cfg.low_threshold  = rfdm_pkg::LOW_THRESHOLD_RST;
			cfg.low_release    = rfdm_pkg::LOW_RELEASE_RST;
			cfg.confirm_count  = rfdm_pkg::CONFIRM_COUNT_RST;
			cfg.clear_count    = rfdm_pkg::CLEAR_COUNT_RST;
			raw_flag       = 1'b0;
			detect_run     = '0;
			clean_run      = '0;
			status         = rfdm_pkg::ST_NONE;
			mismatches     = 0;
			checked        = 0;
			confirmed_seen = 0;
			raw_seen       = 0;
		endfunction

		function void apply_cfg(logic [rfdm_pkg::CFG_IDX_W-1:0] idx,
				logic [rfdm_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				rfdm_pkg::REG_RANGE_MODE:     cfg.mode = rfdm_pkg::range_mode_t'(val[1:0]);
				rfdm_pkg::REG_HIGH_THRESHOLD: cfg.high_threshold = val[rfdm_pkg::LEVEL_W-1:0];
				rfdm_pkg::REG_HIGH_RELEASE:   cfg.high_release = val[rfdm_pkg::LEVEL_W-1:0];
				rfdm_pkg::REG_LOW_THRESHOLD:  cfg.low_threshold = val[rfdm_pkg::LEVEL_W-1:0];
				rfdm_pkg::REG_LOW_RELEASE:    cfg.low_release = val[rfdm_pkg::LEVEL_W-1:0];
				rfdm_pkg::REG_CONFIRM_COUNT:  cfg.confirm_count = val[rfdm_pkg::CNT_W-1:0];
				rfdm_pkg::REG_CLEAR_COUNT:    cfg.clear_count = val[rfdm_pkg::CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [rfdm_pkg::CNT_W-1:0] bump(logic [rfdm_pkg::CNT_W-1:0] t);
			return (t == '1) ? t : t + 1'b1;
		endfunction

		function void take_sample(logic [rfdm_pkg::SAMPLE_W-1:0] meas);
			rfdm_pkg::result_t r;
			case (cfg.mode)
				rfdm_pkg::MODE_ABOVE: begin
					if (meas > cfg.high_threshold) raw_flag = 1'b1;
					else if (meas < cfg.high_release) raw_flag = 1'b0;
				end
				rfdm_pkg::MODE_BELOW: begin
					if (meas < cfg.low_threshold) raw_flag = 1'b1;
					else if (meas > cfg.low_release) raw_flag = 1'b0;
				end
				rfdm_pkg::MODE_WINDOW: begin
					// raising wins over releasing when the levels overlap
					if (meas < cfg.low_threshold || meas > cfg.high_threshold) raw_flag = 1'b1;
					else if (meas > cfg.low_release && meas < cfg.high_release) raw_flag = 1'b0;
				end
				default: raw_flag = 1'b0;
			endcase

			if (raw_flag && (status == rfdm_pkg::ST_NONE || status == rfdm_pkg::ST_PENDING)) begin
				detect_run = bump(detect_run);
				clean_run  = '0;
				status = (detect_run >= cfg.confirm_count) ?
					rfdm_pkg::ST_CONFIRMED : rfdm_pkg::ST_PENDING;
			end else if (!raw_flag && status == rfdm_pkg::ST_CONFIRMED) begin
				clean_run  = bump(clean_run);
				detect_run = '0;
				if (clean_run >= cfg.clear_count) status = rfdm_pkg::ST_NONE;
			end else begin
				detect_run = '0;
				clean_run  = '0;
				if (status != rfdm_pkg::ST_CONFIRMED) status = rfdm_pkg::ST_NONE;
			end

			r.fault_state = status;
			r.raw_fault   = raw_flag;
			status_due.push_back(r);
		endfunction

		function void check_status(logic [rfdm_pkg::OUT_DATA_W-1:0] data);
			rfdm_pkg::result_t exp_r;
			if (status_due.size() == 0) begin
				$error("unexpected result transaction: tdata=%0h", data);
				mismatches++;
				return;
			end
			exp_r = status_due.pop_front();
			checked++;
			if (data[1:0] == rfdm_pkg::ST_CONFIRMED) confirmed_seen++;
			if (data[2]) raw_seen++;
			if (data[1:0] !== exp_r.fault_state) begin
				$error("fault_state: expected %0d, actual %0d", exp_r.fault_state, data[1:0]);
				mismatches++;
			end
			if (data[2] !== exp_r.raw_fault) begin
				$error("raw_fault: expected %0b, actual %0b", exp_r.raw_fault, data[2]);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return status_due.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [rfdm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rfdm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [rfdm_pkg::SAMPLE_W-1:0]   s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [rfdm_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	fault_status_tracker tracker = new();
	int idle_pct = 0;
	int samples_sent = 0;
	int settings_used = 0;
	int cycles = 0;
	int stall_left = 0;

	range_fault_debounce_monitor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, tracker.outstanding());
			$display("simulation failed");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// result side: check accepted transactions, then stall at random
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 99) < idle_pct) stall_left = pick_gap();
			end
		end
	end

	task automatic send_sample(input logic [rfdm_pkg::SAMPLE_W-1:0] meas);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= meas;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_sample(meas);
		samples_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rfdm_pkg::CFG_IDX_W-1:0] idx,
			input logic [rfdm_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.apply_cfg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input rfdm_pkg::range_mode_t mode, input int ht, input int hr,
			input int lt, input int lr, input int conf, input int clr);
		logic [rfdm_pkg::CFG_DATA_W-1:0] junk;
		junk = 16'($urandom);
		// upper bits beyond the register width must be ignored
		write_reg(rfdm_pkg::REG_RANGE_MODE, {junk[15:2], mode});
		write_reg(rfdm_pkg::REG_HIGH_THRESHOLD, 16'(ht));
		write_reg(rfdm_pkg::REG_HIGH_RELEASE, 16'(hr));
		write_reg(rfdm_pkg::REG_LOW_THRESHOLD, 16'(lt));
		write_reg(rfdm_pkg::REG_LOW_RELEASE, 16'(lr));
		write_reg(rfdm_pkg::REG_CONFIRM_COUNT, {junk[7:0], 8'(conf)});
		write_reg(rfdm_pkg::REG_CLEAR_COUNT, {junk[15:8], 8'(clr)});
		settings_used++;
	endtask

	function automatic logic [rfdm_pkg::SAMPLE_W-1:0] pick_sample(pick_t kind);
		int lo, hi, base;
		rfdm_pkg::cfg_t c;
		c = tracker.cfg;
		lo = 0;
		hi = 65535;
		case (kind)
			PICK_HIGH: lo = int'(c.high_threshold) + 1;
			PICK_LOW:  hi = int'(c.low_threshold) - 1;
			PICK_CLEAN: begin
				case (c.mode)
					rfdm_pkg::MODE_ABOVE:  hi = int'(c.high_release) - 1;
					rfdm_pkg::MODE_BELOW:  lo = int'(c.low_release) + 1;
					rfdm_pkg::MODE_WINDOW: begin
						lo = int'(c.low_release) + 1;
						hi = int'(c.high_release) - 1;
					end
					default: ;
				endcase
			end
			PICK_EDGE: begin
				case ($urandom_range(0, 3))
					0: base = int'(c.high_threshold);
					1: base = int'(c.high_release);
					2: base = int'(c.low_threshold);
					default: base = int'(c.low_release);
				endcase
				base = base + int'($urandom_range(0, 2)) - 1;
				if (base < 0) base = 0;
				if (base > 65535) base = 65535;
				return base[15:0];
			end
			default: begin
				if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
		endcase
		if (lo > hi) begin
			lo = 0;
			hi = 65535;
		end
		// lean toward the edges of the chosen band
		if (kind != PICK_ANY && $urandom_range(0, 2) == 0) begin
			if ($urandom_range(0, 1)) return 16'($urandom_range((lo + 3 > hi) ? hi : lo + 3, lo));
			return 16'($urandom_range(hi, (hi - 3 < lo) ? lo : hi - 3));
		end
		return 16'($urandom_range(hi, lo));
	endfunction

	function automatic pick_t fault_kind();
		case (tracker.cfg.mode)
			rfdm_pkg::MODE_ABOVE: return PICK_HIGH;
			rfdm_pkg::MODE_BELOW: return PICK_LOW;
			default:    return $urandom_range(0, 1) ? PICK_HIGH : PICK_LOW;
		endcase
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return 255;
			2:       return $urandom_range(0, 255);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic configure_random();
		int ht, hr, lt, lr, r;
		rfdm_pkg::range_mode_t mode;
		r = $urandom_range(0, 9);
		mode = (r == 0) ? rfdm_pkg::MODE_OFF : rfdm_pkg::range_mode_t'(r % 3);
		case ($urandom_range(0, 3))
			0, 1: begin
				lt = $urandom_range(1, 20000);
				lr = lt + $urandom_range(0, 500);
				hr = $urandom_range(60000, lr + 1000);
				ht = hr + $urandom_range(0, 2000);
			end
			2: begin
				ht = $urandom_range(0, 65535);
				hr = $urandom_range(0, 65535);
				lt = $urandom_range(0, 65535);
				lr = $urandom_range(0, 65535);
			end
			default: begin
				ht = $urandom_range(0, 1) ? 65535 : 0;
				hr = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
				lt = $urandom_range(0, 1) ? 0 : 65535;
				lr = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
			end
		endcase
		write_all(mode, ht, hr, lt, lr, pick_count(), pick_count());
		if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));
	endtask

	// bursts of fault, clean, edge and arbitrary samples sized around the debounce counts
	task automatic run_random_phase(input int n_items, input bit force_pause);
		int sent, run, cap, k, pause_at;
		pick_t kind;
		sent = 0;
		cap = int'(tracker.cfg.confirm_count);
		if (int'(tracker.cfg.clear_count) > cap) cap = int'(tracker.cfg.clear_count);
		cap = cap + 2;
		if (cap > 12) cap = 12;
		if (force_pause) pause_at = n_items / 2;
		else pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_items) : -1;
		while (sent < n_items) begin
			k = $urandom_range(0, 9);
			if (k < 4) kind = fault_kind();
			else if (k < 7) kind = PICK_CLEAN;
			else if (k < 9) kind = PICK_EDGE;
			else kind = PICK_ANY;
			run = $urandom_range(1, cap);
			repeat (run) begin
				send_sample(pick_sample(kind));
				sent++;
			end
			if (pause_at >= 0 && sent >= pause_at) begin
				drain_results();
				pause_at = -1;
			end
		end
	endtask

	initial begin
		int phase, directed_total;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, above range: confirm after three, clear after five clean
		send_sample(16'd0);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'd32000);
		send_sample(16'd31000);
		send_sample(16'd30999);
		repeat (4) send_sample(16'd0);
		drain_results();

		// below range with zero counts: confirm and clear on the first sample
		write_all(rfdm_pkg::MODE_BELOW, 32000, 31000, 2000, 2100, 0, 0);
		send_sample(16'hFFFF);
		send_sample(16'd0);
		send_sample(16'd2000);
		send_sample(16'd2101);
		send_sample(16'd1999);
		send_sample(16'd2100);
		drain_results();

		// window with release levels beyond the thresholds
		write_all(rfdm_pkg::MODE_WINDOW, 50000, 52000, 3000, 2500, 1, 1);
		send_sample(16'd51000);
		send_sample(16'd45000);
		send_sample(16'd2800);
		send_sample(16'd3000);
		send_sample(16'd50001);
		drain_results();

		// detection off; a write past the register list is dropped
		write_all(rfdm_pkg::MODE_OFF, 0, 65535, 65535, 0, 255, 255);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'd0);
		drain_results();
		directed_total = samples_sent;

		phase = 0;
		while (samples_sent < directed_total + RANDOM_SAMPLES) begin
			if (phase == 3) begin
				// longest confirm: the detection tally runs all the way to its top
				write_all(rfdm_pkg::MODE_ABOVE, 1000, 900, 0, 0, 255, 2);
				idle_pct = 15;
				repeat (256) send_sample(pick_sample(PICK_HIGH));
				repeat (3) send_sample(pick_sample(PICK_CLEAN));
			end else begin
				configure_random();
				idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 40);
				run_random_phase($urandom_range(20, 60), phase == 0);
			end
			drain_results();
			phase++;
		end

		drain_results();
		$display("%0d samples across %0d register settings, %0d results checked",
			samples_sent, settings_used, tracker.checked);
		$display("%0d confirmed results, %0d with the raw flag set",
			tracker.confirmed_seen, tracker.raw_seen);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
